// ----- rtl/sha_pkg.sv -----
// Shared types, constants and functions of the SHA-256 stream hasher.
// Depends on nothing; every other file but sha_checker imports it.
`timescale 1ns / 1ps
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic       absorb;
    logic       pad;
    logic       load_len;
    logic       start;
    logic       round;
    logic       add;
    logic       rearm;
    logic [5:0] round_idx;
    logic [2:0] word_sel;
  } sha_cmd_t;

  typedef struct packed {
    logic full;
    logic two_blocks;
  } sha_sts_t;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/sha_if.sv -----
// Valid/ready channel interfaces for the input beats and the digest beats.
// Depends on sha_pkg.
`timescale 1ns / 1ps
interface sha_in_if import sha_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface sha_out_if import sha_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      digest_word;
  logic [2:0] word_index;
  logic       last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/sha_datapath.sv -----
// Datapath: block buffer as a sixteen-word schedule window, working variables,
// hash words, fill and length counters, and the single round unit. Uses sha_pkg.
`timescale 1ns / 1ps
module sha_datapath import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sha_cmd_t   cmd,
  input  logic [7:0] data_byte,
  output sha_sts_t   sts,
  output word_t      digest_word
);

  word_t       w_r    [16];
  word_t       w_nxt  [16];
  word_t       v_r    [8];
  word_t       v_nxt  [8];
  word_t       hash_r [8];
  word_t       hash_nxt [8];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;

  word_t s0, s1, w_new, big0, big1, ch, maj, t1, t2;
  logic [5:0] bidx;

  assign sts.full       = (fill_r == 6'd63);
  assign sts.two_blocks = (fill_r >= LEN_POS);
  assign digest_word    = hash_r[cmd.word_sel];

  always_comb begin
    s0    = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    big1  = ror32(v_r[4], 6) ^ ror32(v_r[4], 11) ^ ror32(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + ch + ROUND_K[cmd.round_idx] + w_r[0];
    big0  = ror32(v_r[0], 2) ^ ror32(v_r[0], 13) ^ ror32(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = big0 + maj;
  end

  always_comb begin
    w_nxt    = w_r;
    v_nxt    = v_r;
    hash_nxt = hash_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    bidx     = '0;
    if (cmd.absorb) begin
      w_nxt[fill_r[5:2]][(2'd3 - fill_r[1:0]) * 8 +: 8] = data_byte;
      fill_nxt = fill_r + 6'd1;
      bits_nxt = bits_r + 64'd8;
    end
    if (cmd.pad) begin
      for (int j = 0; j < 16; j++) begin
        for (int b = 0; b < 4; b++) begin
          bidx = 6'(j * 4 + b);
          if (bidx == fill_r) begin
            w_nxt[j][(3 - b) * 8 +: 8] = PAD_BYTE;
          end else if (bidx > fill_r) begin
            w_nxt[j][(3 - b) * 8 +: 8] = 8'h00;
          end
        end
      end
      if (!sts.two_blocks) begin
        w_nxt[14] = bits_r[63:32];
        w_nxt[15] = bits_r[31:0];
      end
    end
    if (cmd.load_len) begin
      for (int j = 0; j < 14; j++) begin
        w_nxt[j] = '0;
      end
      w_nxt[14] = bits_r[63:32];
      w_nxt[15] = bits_r[31:0];
    end
    if (cmd.start) begin
      v_nxt = hash_r;
    end
    if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        w_nxt[j] = w_r[j + 1];
      end
      w_nxt[15] = w_new;
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
    if (cmd.add) begin
      for (int j = 0; j < 8; j++) begin
        hash_nxt[j] = hash_r[j] + v_r[j];
      end
    end
    if (cmd.rearm) begin
      hash_nxt = INIT_HASH;
      fill_nxt = '0;
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
    if (!rst_n) begin
      hash_r <= INIT_HASH;
      fill_r <= '0;
      bits_r <= '0;
    end else begin
      hash_r <= hash_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
    end
  end

endmodule

// ----- rtl/sha_ctrl.sv -----
// Controller: sequences absorb, padding, the 64 rounds, the final addition, the
// length-only block and the eight digest beats. Uses sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_action,
  output logic     out_valid,
  input  logic     out_ready,
  output logic [2:0] out_word_index,
  output logic     out_last_word,
  input  sha_sts_t sts,
  output sha_cmd_t cmd
);

  typedef enum logic [2:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_LEN, ST_EMIT} state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;
  logic       two_r, two_nxt;

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    two_nxt       = two_r;
    cmd           = '0;
    cmd.round_idx = rnd_r;
    cmd.word_sel  = idx_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rnd_nxt = '0;
          if (in_action == ACT_ABSORB) begin
            cmd.absorb = 1'b1;
            if (sts.full) begin
              cmd.start = 1'b1;
              fin_nxt   = 1'b0;
              state_nxt = ST_ROUND;
            end
          end else begin
            cmd.pad   = 1'b1;
            cmd.start = 1'b1;
            fin_nxt   = 1'b1;
            two_nxt   = sts.two_blocks;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (fin_r && two_r) begin
          state_nxt = ST_LEN;
        end else if (fin_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LEN: begin
        cmd.load_len = 1'b1;
        cmd.start    = 1'b1;
        two_nxt      = 1'b0;
        rnd_nxt      = '0;
        state_nxt    = ST_ROUND;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.rearm = 1'b1;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      two_r   <= two_nxt;
    end
  end

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// SHA-256 stream hasher: takes a message one byte per beat and, on a finish
// beat, returns the eight digest words h0 first. The absorb beat that fills
// a 64-byte block is followed by 64 rounds through the single round unit,
// one per cycle, and an addition of the working variables into the hash
// words. A finish beat pads the block and compresses it, and also compresses
// a block holding only the length when fewer than nine bytes remain free in
// the block; eight digest beats follow at one per cycle while the consumer
// is ready. No input is taken during compression or digest output.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_datapath.
`timescale 1ns / 1ps
module sha256_stream_hasher import sha_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  sha_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_action      (in_ch.action),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_word_index (out_ch.word_index),
    .out_last_word  (out_ch.last_word),
    .sts            (sts),
    .cmd            (cmd)
  );

  sha_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .sts         (sts),
    .digest_word (out_ch.digest_word)
  );

endmodule

// ----- rtl/sha_checker.sv -----
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on the top level's channel interfaces.
`timescale 1ns / 1ps
module sha_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_word_index,
  input logic       out_last_word
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_index))
    else $error("digest beat dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken during digest output");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last flag not on the eighth word");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words not consecutive");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid && in_ready)
    else $error("block not re-armed after digest");

endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_index (out_ch.word_index),
  .out_last_word  (out_ch.last_word)
);
